>>> rtl/core/bofm_pkg.sv
// Package for the bar order fill matcher: order record, fill record,
// function, kind and side codes. No dependencies.
`timescale 1ns / 1ps

package bofm_pkg;

  // Input function codes
  localparam logic [1:0] FUNC_PLACE  = 2'd0;
  localparam logic [1:0] FUNC_CANCEL = 2'd1;
  localparam logic [1:0] FUNC_BAR    = 2'd2;

  // Order kinds
  localparam logic [1:0] KIND_MARKET = 2'd0;
  localparam logic [1:0] KIND_LIMIT  = 2'd1;
  localparam logic [1:0] KIND_STOP   = 2'd2;

  localparam logic SIDE_SELL = 1'b1;

  // Fills one bar may produce
  localparam logic [4:0] MAX_FILLS = 5'd16;

  localparam int PRICE_W = 32;
  localparam int QTY_W   = 24;
  localparam int COMM_W  = 56;
  localparam int RATE_W  = 20;

  typedef struct packed {
    logic               valid;
    logic [1:0]         kind;
    logic               side;
    logic [PRICE_W-1:0] limit;
    logic [PRICE_W-1:0] stop;
    logic [QTY_W-1:0]   qty;
  } order_t;

  typedef struct packed {
    logic [3:0]         slot;
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
    logic [31:0]        tnum;
  } fill_t;

endpackage

>>> rtl/core/bofm_cell.sv
// One order slot of the circulating order ring.
// Depends on bofm_pkg for order_t.
`timescale 1ns / 1ps

module bofm_cell
  import bofm_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   shift,
  input  order_t nbr,
  input  logic   wr,
  input  order_t wdata,
  output order_t data
);

  // Load a written order, or take the neighbor's order on a ring step
  always_ff @(posedge clk) begin
    if (rst) begin
      data <= '0;
    end else if (wr) begin
      data <= wdata;
    end else if (shift) begin
      data <= nbr;
    end
  end

endmodule

>>> rtl/core/bofm_comm.sv
// Two-stage commission multiplier: price * qty, then times rate, then
// scale and saturate. Depends on bofm_pkg for widths.
`timescale 1ns / 1ps

module bofm_comm
  import bofm_pkg::*;
#(
  parameter int FRAC = 20
) (
  input  logic               clk,
  input  logic               en,
  input  logic [PRICE_W-1:0] price,
  input  logic [QTY_W-1:0]   qty,
  input  logic [RATE_W-1:0]  rate,
  output logic [COMM_W-1:0]  comm
);

  localparam int PQ_W   = PRICE_W + QTY_W;
  localparam int HI_W   = PQ_W - 32;
  localparam int FULL_W = PQ_W + RATE_W;

  logic [PQ_W-1:0]        pq;
  logic [HI_W+RATE_W-1:0] hir;
  logic [32+RATE_W-1:0]   lor;
  logic [FULL_W-1:0]      full;
  logic [FULL_W-1:0]      scaled;

  // Stage one: price times quantity; stage two: both halves times rate
  always_ff @(posedge clk) begin
    if (en) begin
      pq  <= PQ_W'(price) * PQ_W'(qty);
      hir <= (HI_W+RATE_W)'(pq[PQ_W-1:32]) * (HI_W+RATE_W)'(rate);
      lor <= (32+RATE_W)'(pq[31:0]) * (32+RATE_W)'(rate);
    end
  end

  // Recombine halves, drop fraction bits, saturate to output width
  always_comb begin
    full   = (FULL_W'(hir) << 32) + FULL_W'(lor);
    scaled = full >> FRAC;
    if (scaled[FULL_W-1:COMM_W] != '0) begin
      comm = '1;
    end else begin
      comm = scaled[COMM_W-1:0];
    end
  end

endmodule

>>> rtl/core/bar_order_fill_matcher.sv
// Place and cancel write the addressed slot of the order table; a bar scans
// every slot as the ring passes the match logic and commission multiplier.
// The ring steps one slot per cycle while the output is not stalled. New words
// are accepted only while idle, so one bar completes before the next is taken.
// Output stalls freeze the ring and the multiplier pipeline.
// Reset (synchronous): table empty, trade count and commission rate zero.
`timescale 1ns / 1ps

module bar_order_fill_matcher
  import bofm_pkg::*;
#(
  parameter int ORDER_SLOTS    = 16,
  parameter int RATE_FRAC_BITS = 20
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [RATE_W-1:0]  cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         func,
  input  logic [3:0]         slot,
  input  logic [1:0]         order_kind,
  input  logic               side,
  input  logic [PRICE_W-1:0] limit_price,
  input  logic [PRICE_W-1:0] stop_price,
  input  logic [QTY_W-1:0]   quantity,
  input  logic [47:0]        bar_time,
  input  logic [PRICE_W-1:0] bar_high,
  input  logic [PRICE_W-1:0] bar_low,
  input  logic [PRICE_W-1:0] bar_close,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         fill_slot,
  output logic               fill_side,
  output logic [PRICE_W-1:0] fill_price,
  output logic [QTY_W-1:0]   fill_quantity,
  output logic [COMM_W-1:0]  commission,
  output logic [47:0]        fill_time,
  output logic [31:0]        trade_number,
  output logic               last
);

  localparam int IW = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(ORDER_SLOTS - 1);
  localparam logic [8:0] SLOTS9 = 9'(ORDER_SLOTS);

  logic [RATE_W-1:0]  rate;
  logic               scanning;
  logic [IW-1:0]      cnt;
  logic [8:0]         cnt9;
  logic [4:0]         fcnt;
  logic [31:0]        trade_count;
  logic [31:0]        tnum_next;
  logic [47:0]        tbar;
  logic [PRICE_W-1:0] hi_r, lo_r, cl_r;

  logic               p1_v, p1_end, p2_v, p2_end, held_v, flush;
  fill_t              p1, p2, held;
  logic [COMM_W-1:0]  held_comm, comm_w;

  order_t             cells [ORDER_SLOTS];
  order_t             head, tail_in, wdata;
  logic               en, idle, accept, hit;
  logic [PRICE_W-1:0] px;
  logic [8:0]         slot9;
  logic [IW-1:0]      widx;
  logic               wr_any;

  assign en     = !out_valid || !out_stall;
  assign idle   = !scanning && !p1_v && !p1_end && !p2_v && !p2_end && !held_v && !flush;
  assign in_stall = !idle;
  assign accept = in_valid && idle;

  assign slot9  = 9'(slot);
  assign widx   = slot9[IW-1:0];
  assign wr_any = accept && (func == FUNC_PLACE || func == FUNC_CANCEL) && (slot9 < SLOTS9);
  assign cnt9   = 9'(cnt);

  always_comb begin
    wdata.valid = (func == FUNC_PLACE);
    wdata.kind  = order_kind;
    wdata.side  = side;
    wdata.limit = limit_price;
    wdata.stop  = stop_price;
    wdata.qty   = quantity;
  end

  // Match the order at the head of the ring against the bar
  assign head = cells[0];
  always_comb begin
    hit = 1'b0;
    px  = '0;
    unique case (head.kind)
      KIND_MARKET: begin
        hit = 1'b1;
        px  = cl_r;
      end
      KIND_LIMIT: begin
        hit = (head.side == SIDE_SELL) ? (head.limit <= hi_r) : (head.limit >= lo_r);
        px  = head.limit;
      end
      KIND_STOP: begin
        hit = (head.side == SIDE_SELL) ? (lo_r <= head.stop) : (hi_r >= head.stop);
        px  = head.stop;
      end
      default: begin
        hit = 1'b0;
        px  = '0;
      end
    endcase
    hit = hit && head.valid && scanning && (fcnt < MAX_FILLS);
  end

  // Free the head slot when it fills as it wraps to the tail
  always_comb begin
    tail_in = head;
    if (hit) begin
      tail_in.valid = 1'b0;
    end
  end

  assign tnum_next = (trade_count == '1) ? trade_count : trade_count + 32'd1;

  // Order ring
  for (genvar k = 0; k < ORDER_SLOTS; k++) begin : g_cell
    bofm_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (scanning && en),
      .nbr   ((k == ORDER_SLOTS - 1) ? tail_in : cells[(k + 1) % ORDER_SLOTS]),
      .wr    (wr_any && (widx == IW'(k))),
      .wdata (wdata),
      .data  (cells[k])
    );
  end

  bofm_comm #(.FRAC(RATE_FRAC_BITS)) u_comm (
    .clk   (clk),
    .en    (en),
    .price (px),
    .qty   (head.qty),
    .rate  (rate),
    .comm  (comm_w)
  );

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      rate <= '0;
    end else if (cfg_wr_en) begin
      rate <= cfg_wr_data;
    end
  end

  // Scan control, trade counter and bar capture
  always_ff @(posedge clk) begin
    if (rst) begin
      scanning    <= 1'b0;
      cnt         <= '0;
      fcnt        <= '0;
      trade_count <= '0;
    end else if (accept && func == FUNC_BAR) begin
      scanning <= 1'b1;
      cnt      <= '0;
      fcnt     <= '0;
    end else if (scanning && en) begin
      cnt <= cnt + IW'(1);
      if (cnt == LAST_IDX) begin
        scanning <= 1'b0;
      end
      if (hit) begin
        fcnt        <= fcnt + 5'd1;
        trade_count <= tnum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && func == FUNC_BAR) begin
      tbar <= bar_time;
      hi_r <= bar_high;
      lo_r <= bar_low;
      cl_r <= bar_close;
    end
  end

  // Fill pipeline control: match, multiply, hold for last-flag decision
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v      <= 1'b0;
      p1_end    <= 1'b0;
      p2_v      <= 1'b0;
      p2_end    <= 1'b0;
      held_v    <= 1'b0;
      flush     <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      p1_v      <= hit;
      p1_end    <= scanning && (cnt == LAST_IDX);
      p2_v      <= p1_v;
      p2_end    <= p1_end;
      out_valid <= 1'b0;
      if (p2_v) begin
        held_v <= 1'b1;
        if (held_v) begin
          out_valid <= 1'b1;
        end
      end else if (flush) begin
        held_v <= 1'b0;
        if (held_v) begin
          out_valid <= 1'b1;
        end
      end
      if (p2_end) begin
        flush <= 1'b1;
      end else if (flush && !p2_v) begin
        flush <= 1'b0;
      end
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      p1.slot  <= cnt9[3:0];
      p1.side  <= head.side;
      p1.price <= px;
      p1.qty   <= head.qty;
      p1.tnum  <= tnum_next;
      p2       <= p1;
      if (p2_v) begin
        held      <= p2;
        held_comm <= comm_w;
      end
      if ((p2_v || flush) && held_v) begin
        fill_slot     <= held.slot;
        fill_side     <= held.side;
        fill_price    <= held.price;
        fill_quantity <= held.qty;
        commission    <= held_comm;
        fill_time     <= tbar;
        trade_number  <= held.tnum;
        last          <= !p2_v;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_cap: assert property (@(posedge clk) disable iff (rst) fcnt <= MAX_FILLS)
    else $error("fill count beyond per-bar limit");
  a_no_flush_scan: assert property (@(posedge clk) disable iff (rst)
    scanning |-> !flush)
    else $error("flush during scan");
  a_trade_mono: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> trade_count >= $past(trade_count))
    else $error("trade count went backwards");
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !scanning && !held_v)
    else $error("accepting word while bar in flight");
`endif

endmodule
